FILE: rtl/tli_pkg.sv
`default_nettype none

package tli_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned COS_W = 16;
  localparam int unsigned PDF_W = 24;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned PTS_W = 7;
  localparam int unsigned ERR_W = 2;

  // Divider operand widths: |(p2-p1)*(mu-d1)| < 2^40 and |d2-d1| <= 65535.
  localparam int unsigned NUM_W = 40;
  localparam int unsigned DEN_W = 16;

  localparam logic [PDF_W-1:0] PDF_MAX = {PDF_W{1'b1}};
  localparam logic [PTS_W-1:0] PTS_RESET = 7'd2;

  // Request modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result error codes.
  localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BELOW      = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO_WIDTH = 2'd2;

  typedef logic signed [COS_W-1:0] cos_t;
  typedef logic [PDF_W-1:0] pdf_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/tli_if.sv
`default_nettype none

// Request channel: table loads and queries.
interface tli_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [tli_pkg::IDX_W-1:0]         point_index;
  logic signed [tli_pkg::COS_W-1:0]  cosine;
  logic [tli_pkg::PDF_W-1:0]         pdf_value;

  modport source (output valid, mode, point_index, cosine, pdf_value, input ready);
  modport sink (input valid, mode, point_index, cosine, pdf_value, output ready);
endinterface

// Result channel: one result per query.
interface tli_out_if;
  logic                        valid;
  logic                        ready;
  logic [tli_pkg::PDF_W-1:0]   pdf_result;
  logic [tli_pkg::IDX_W-1:0]   interval_found;
  logic [tli_pkg::ERR_W-1:0]   error_code;

  modport source (output valid, pdf_result, interval_found, error_code, input ready);
  modport sink (input valid, pdf_result, interval_found, error_code, output ready);
endinterface

// Configuration write channel for the point count.
interface tli_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tli_pkg::PTS_W-1:0]   points_in_use;

  modport source (output valid, points_in_use, input ready);
  modport sink (input valid, points_in_use, output ready);
endinterface

`default_nettype wire

FILE: rtl/tli_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module tli_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tli_pkg::NUM_W-1:0]   dividend,
  input  wire logic [tli_pkg::DEN_W-1:0]   divisor,
  output logic [tli_pkg::NUM_W-1:0]        quotient,
  output tli_pkg::div_status_t             status
);

  localparam int unsigned CNT_W = $clog2(tli_pkg::NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tli_pkg::NUM_W - 1);

  logic [tli_pkg::DEN_W-1:0] rem;
  logic [tli_pkg::NUM_W-1:0] quo;
  logic [tli_pkg::DEN_W-1:0] den;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;

  logic [tli_pkg::DEN_W:0]   shifted;
  logic                      ge;
  logic [tli_pkg::DEN_W:0]   diff;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    shifted = {rem, quo[tli_pkg::NUM_W-1]};
    diff    = shifted - {1'b0, den};
    ge      = (shifted >= {1'b0, den});
  end

  // Control state of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[tli_pkg::DEN_W-1:0] : shifted[tli_pkg::DEN_W-1:0];
      quo <= {quo[tli_pkg::NUM_W-2:0], ge};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

FILE: rtl/table_linear_interpolator.sv
`default_nettype none

// Piecewise linear table interpolator. A load request (mode 0) writes one
// cosine/PDF pair into the table in the cycle it is accepted; indexes at or
// above MAX_POINTS are ignored. A query request (mode 1) scans the table from
// the first interval upward for the first upper point above the query, falling
// back to the last interval, then returns p1 + (p2-p1)*(mu-d1)/(d2-d1),
// truncated toward zero and saturated to 0..16777215, with the lower point's
// index and an error code (below the table, or zero-width interval). One
// request is handled at a time. A query reads and compares each scanned
// entry through the single table read port, fetches the end points, does the
// range check and product, starts the divider, waits for the 40-step
// bit-serial divider and its done flag, adds and saturates, and loads the
// result register. An error skips the division. A result that waits in the
// output register while a second query is done holds the block until it is
// taken. The user must write the point count through the configuration
// channel only while the block is idle; the block itself does not enforce
// this. Counts below 2 act as 2 and counts above MAX_POINTS act as MAX_POINTS.
module table_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  tli_cfg_if.sink   cfg,
  tli_in_if.sink    item,
  tli_out_if.source result
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_FETCH_LO = 4'd3;
  localparam logic [3:0] S_FETCH_P1 = 4'd4;
  localparam logic [3:0] S_FETCH_P2 = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd6;
  localparam logic [3:0] S_MUL      = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  // Table storage.
  tli_pkg::cos_t cos_mem [MAX_POINTS];
  tli_pkg::pdf_t pdf_mem [MAX_POINTS];
  tli_pkg::cos_t cos_rd;
  tli_pkg::pdf_t pdf_rd;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;

  // Control and working registers.
  logic [3:0]                  state;
  logic [3:0]                  state_next;
  logic [tli_pkg::PTS_W-1:0]   points;
  logic [AW-1:0]               k;
  logic [AW-1:0]               last_k;
  tli_pkg::cos_t               mu;
  tli_pkg::cos_t               d1;
  tli_pkg::cos_t               d2;
  tli_pkg::pdf_t               p1;
  tli_pkg::pdf_t               p2;
  logic signed [42:0]          prod;
  logic signed [16:0]          den;
  logic                        neg;
  tli_pkg::pdf_t               res;
  logic [tli_pkg::ERR_W-1:0]   err;

  logic signed [24:0]          dp;
  logic signed [17:0]          dm;
  logic signed [42:0]          prod_next;
  logic signed [16:0]          den_next;
  logic [42:0]                 prod_abs;
  logic [16:0]                 den_abs;
  logic signed [41:0]          sum;
  tli_pkg::pdf_t               sat;

  logic                        div_start;
  logic [tli_pkg::NUM_W-1:0]   quotient;
  tli_pkg::div_status_t        div_status;

  logic                        out_valid;
  logic                        item_fire;
  logic                        out_load;

  assign cfg.ready   = 1'b1;
  assign item.ready  = (state == S_IDLE);
  assign item_fire   = item.valid && item.ready;
  assign out_load    = (state == S_DONE) && (!out_valid || result.ready);
  assign div_start   = (state == S_MUL);

  // Point count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      points <= tli_pkg::PTS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      points <= cfg.points_in_use;
    end
  end

  // Index of the last interval, from the clamped point count.
  always_comb begin
    if (points < 7'd2) begin
      last_k = '0;
    end else if (32'(points) > 32'(MAX_POINTS)) begin
      last_k = AW'(MAX_POINTS - 2);
    end else begin
      last_k = AW'(points - 7'd2);
    end
  end

  // Table write on a load request.
  assign we    = item_fire && (item.mode == tli_pkg::MODE_LOAD) &&
                 (32'(item.point_index) < 32'(MAX_POINTS));
  assign waddr = AW'(item.point_index);

  // Read address follows the sequencer step.
  always_comb begin
    unique case (state)
      S_SCAN_RD:  raddr = k + 1'b1;
      S_FETCH_P1: raddr = k + 1'b1;
      default:    raddr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cos_mem[waddr] <= item.cosine;
    end
    cos_rd <= cos_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pdf_mem[waddr] <= item.pdf_value;
    end
    pdf_rd <= pdf_mem[raddr];
  end

  // Slope numerator and width of the chosen interval.
  always_comb begin
    dp        = $signed({1'b0, p2}) - $signed({1'b0, p1});
    dm        = $signed({{2{mu[15]}}, mu}) - $signed({{2{d1[15]}}, d1});
    prod_next = dp * dm;
    den_next  = $signed({d2[15], d2}) - $signed({d1[15], d1});
    prod_abs  = prod[42] ? 43'(-prod) : 43'(prod);
    den_abs   = den[16] ? 17'(-den) : 17'(den);
  end

  // Add the signed quotient to p1 and saturate.
  always_comb begin
    sum = $signed({18'b0, p1}) +
          (neg ? -$signed({2'b0, quotient}) : $signed({2'b0, quotient}));
    priority if (sum[41]) begin
      sat = '0;
    end else if (sum > $signed({18'b0, tli_pkg::PDF_MAX})) begin
      sat = tli_pkg::PDF_MAX;
    end else begin
      sat = sum[23:0];
    end
  end

  tli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_abs[tli_pkg::NUM_W-1:0]),
    .divisor  (den_abs[tli_pkg::DEN_W-1:0]),
    .quotient (quotient),
    .status   (div_status)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_fire && (item.mode == tli_pkg::MODE_QUERY)) begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if ((mu < cos_rd) || (k == last_k)) begin
          state_next = S_FETCH_LO;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_FETCH_LO: state_next = S_FETCH_P1;
      S_FETCH_P1: state_next = S_FETCH_P2;
      S_FETCH_P2: state_next = S_CHECK;
      S_CHECK: begin
        if ((mu < d1) || (d2 == d1)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL:    state_next = S_DIV;
      S_DIV: begin
        if (div_status.done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of one query.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mu <= item.cosine;
        k  <= '0;
      end
      S_SCAN_CMP: begin
        if (!((mu < cos_rd) || (k == last_k))) begin
          k <= k + 1'b1;
        end
      end
      S_FETCH_P1: begin
        d1 <= cos_rd;
        p1 <= pdf_rd;
      end
      S_FETCH_P2: begin
        d2 <= cos_rd;
        p2 <= pdf_rd;
      end
      S_CHECK: begin
        prod <= prod_next;
        den  <= den_next;
        res  <= '0;
        priority if (mu < d1) begin
          err <= tli_pkg::ERR_BELOW;
        end else if (d2 == d1) begin
          err <= tli_pkg::ERR_ZERO_WIDTH;
        end else begin
          err <= tli_pkg::ERR_OK;
        end
      end
      S_MUL: begin
        neg <= prod[42] ^ den[16];
      end
      S_FINISH: begin
        res <= sat;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.pdf_result     <= res;
      result.interval_found <= tli_pkg::IDX_W'(k);
      result.error_code     <= err;
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire
